/* src/min_max_segment_partition_assert.svh */
// Assertion macros shared by the partition search block.
`ifndef MIN_MAX_SEGMENT_PARTITION_ASSERT_SVH
`define MIN_MAX_SEGMENT_PARTITION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmsp assertion failed");

// Next-cycle implication, disabled during reset.
`define MMSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmsp assertion failed");

`endif

/* src/mmsp_pkg.sv */
// Package: widths, sequencer states and register map of the partition search block.
package mmsp_pkg;

    localparam int DEPTH   = 1024;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = VALUE_W + $clog2(DEPTH);
    localparam int OUT_W   = 42;
    localparam int WIDE_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int SEG_W   = 11;
    localparam int USED_W  = SEG_W + 1;

    localparam logic [WIDE_W-1:0] OUT_MAX = WIDE_W'({OUT_W{1'b1}});

    localparam int APB_DW  = 32;
    localparam int APB_AW  = 2;

    localparam logic [APB_AW-1:0] REG_SEGMENT_LIMIT = 2'd0;
    localparam logic [SEG_W-1:0]  SEG_LIMIT_RESET   = 11'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MID,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

/* src/mmsp_if.sv */
// Handshake interfaces for the element input channel and the result channel.
interface mmsp_in_if;
    logic                        valid;
    logic                        ready;
    logic [mmsp_pkg::VALUE_W-1:0] element_value;
    logic                        last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface mmsp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mmsp_pkg::OUT_W-1:0] min_max_sum;
    logic                       overflow_flag;

    modport source (output valid, output min_max_sum, output overflow_flag, input ready);
    modport sink   (input valid, input min_max_sum, input overflow_flag, output ready);
endinterface

/* src/min_max_segment_partition.sv */
// Top level: element store, loading totals and binary search over segment limits.
//
// Usage:
//   i_elem carries one array element per item; the item with last_element set
//   closes the array. While idle, elements load at one item per cycle into a
//   1024-entry store; further elements are dropped and flagged in overflow_flag.
//   After the last item the block drops ready and runs a binary search on the
//   limit between the largest element and the total. Each probe is a
//   midpoint step and a scan that walks the store through one read port
//   with a single shared adder and comparator; a search takes about
//   ceil(log2(total-largest+1)) probes. The memory read port sets the
//   probe length. The answer reaches o_res after the last probe, and the
//   next array may load while it waits there.
//   A search that ends while the previous answer still waits holds, with
//   ready low, until the sink takes that answer.
//   segment_limit (APB, address 0) is to be written only while idle; the
//   block does not enforce this. 0 acts as 1. Reset is synchronous and
//   active low: totals, count, flags, the result valid bit and the sequencer
//   state clear, segment_limit returns to 1. The store is not cleared.
`include "min_max_segment_partition_assert.svh"

module min_max_segment_partition (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mmsp_in_if.sink                       i_elem,
    mmsp_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmsp_pkg::APB_AW-1:0]   paddr,
    input  logic [mmsp_pkg::APB_DW-1:0]   pwdata,
    output logic [mmsp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mmsp_pkg::*;

    t_state r_state, n_state;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    logic [SEG_W-1:0]   r_seg_limit;
    logic [SEG_W-1:0]   r_segs;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_total;
    logic [VALUE_W-1:0] r_largest;
    logic               r_ovf;
    logic               r_res_ovf;

    logic [SUM_W-1:0]   r_lo, r_hi, r_mid;
    logic [SUM_W-1:0]   r_run;
    logic [USED_W-1:0]  r_used;
    logic [CNT_W-1:0]   r_issue;
    logic               r_dv;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_sum;
    logic               r_out_ovf;

    logic               in_acc, out_acc, cfg_wr, res_load;
    logic [SUM_W:0]     mid_sum;
    logic [SUM_W:0]     run_sum;
    logic               over_cap, probe_fail, probe_done, search_end;
    logic [WIDE_W-1:0]  lo_wide;
    logic [OUT_W-1:0]   lo_sat;

    // ---------------- control ----------------
    assign in_acc   = i_elem.valid && i_elem.ready;
    assign out_acc  = o_res.valid && o_res.ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign res_load = (r_state == S_OUT) && (!r_out_valid || out_acc);

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign run_sum    = {1'b0, r_run} + {{(SUM_W+1-VALUE_W){1'b0}}, r_rdata};
    assign over_cap   = run_sum > {1'b0, r_mid};
    assign probe_fail = r_dv && over_cap && ((r_used + 1'b1) > {1'b0, r_segs});
    assign probe_done = !r_dv && (r_issue == r_count);
    assign search_end = !(r_lo < r_hi);

    // clamp the answer to the result width
    assign lo_wide = WIDE_W'(r_lo);
    assign lo_sat  = (lo_wide > OUT_MAX) ? '1 : lo_wide[OUT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && i_elem.last_element) n_state = S_INIT;
            S_INIT: n_state = S_MID;
            S_MID:  n_state = search_end ? S_OUT : S_SCAN;
            S_SCAN: if (probe_fail || probe_done) n_state = S_MID;
            S_OUT:  if (res_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_elem.ready        = (r_state == S_IDLE);
        o_res.valid         = r_out_valid;
        o_res.min_max_sum   = r_out_sum;
        o_res.overflow_flag = r_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_sum <= lo_sat;
            r_out_ovf <= r_res_ovf;
        end
    end

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_SEGMENT_LIMIT) ?
                    {{(APB_DW-SEG_W){1'b0}}, r_seg_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_limit <= SEG_LIMIT_RESET;
        end else if (cfg_wr && (paddr == REG_SEGMENT_LIMIT)) begin
            r_seg_limit <= pwdata[SEG_W-1:0];
        end
    end

    // ---------------- element store ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < CNT_W'(DEPTH))) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_elem.element_value;
        end
        r_rdata <= r_mem[r_issue[ADDR_W-1:0]];
    end

    // ---------------- loading totals ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_total   <= '0;
            r_largest <= '0;
            r_ovf     <= 1'b0;
            r_res_ovf <= 1'b0;
        end else if (in_acc) begin
            if (r_count < CNT_W'(DEPTH)) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + {{(SUM_W-VALUE_W){1'b0}}, i_elem.element_value};
                if (i_elem.element_value > r_largest) begin
                    r_largest <= i_elem.element_value;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end else if ((r_state == S_MID) && search_end) begin
            // hand the flag to the result and clear for the next array
            r_res_ovf <= r_ovf;
            r_count   <= '0;
            r_total   <= '0;
            r_largest <= '0;
            r_ovf     <= 1'b0;
        end
    end

    // ---------------- search sequencer datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= 1'b0;
            r_issue <= '0;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    r_lo   <= {{(SUM_W-VALUE_W){1'b0}}, r_largest};
                    r_hi   <= r_total;
                    r_segs <= (r_seg_limit == '0) ? SEG_W'(1) : r_seg_limit;
                end
                S_MID: begin
                    r_mid   <= mid_sum[SUM_W:1];
                    r_run   <= '0;
                    r_used  <= USED_W'(1);
                    r_issue <= '0;
                    r_dv    <= 1'b0;
                end
                S_SCAN: begin
                    // issue the next read while the previous element is packed
                    if (r_issue < r_count) begin
                        r_issue <= r_issue + 1'b1;
                        r_dv    <= 1'b1;
                    end else begin
                        r_dv    <= 1'b0;
                    end
                    if (r_dv) begin
                        if (over_cap) begin
                            r_used <= r_used + 1'b1;
                            r_run  <= {{(SUM_W-VALUE_W){1'b0}}, r_rdata};
                        end else begin
                            r_run  <= run_sum[SUM_W-1:0];
                        end
                    end
                    if (probe_fail) begin
                        r_lo <= r_mid + 1'b1;
                    end else if (probe_done) begin
                        r_hi <= r_mid;
                    end
                end
                default: begin
                    r_dv <= 1'b0;
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    `MMSP_ASSERT_NXT(a_result_held, i_clk, i_rst_n,
                     o_res.valid && !o_res.ready, o_res.valid)
    `MMSP_ASSERT_IMP(a_bounds_ordered, i_clk, i_rst_n,
                     r_state == S_MID, r_lo <= r_hi)
    `MMSP_ASSERT_NXT(a_result_stable, i_clk, i_rst_n,
                     o_res.valid && !o_res.ready,
                     $stable(o_res.min_max_sum) && $stable(o_res.overflow_flag))

endmodule

/* dv/tb_min_max_segment_partition.sv */
// Testbench for min_max_segment_partition: array loads, limit search results, overflow flag.
`timescale 1ns / 1ps

module tb_min_max_segment_partition;
    import mmsp_pkg::*;

    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [OUT_W-1:0] min_max_sum;
        logic             overflow_flag;
    } t_partition_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mmsp_in_if  elem_if ();
    mmsp_out_if res_if ();

    min_max_segment_partition uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the block: current array, its overflow, and the segment limit.
    logic [VALUE_W-1:0] loaded_values[$];
    logic               overflow_pending = 1'b0;
    logic [SEG_W-1:0]   seg_limit_shadow = SEG_LIMIT_RESET;
    t_partition_answer  pending_answers[$];

    int mismatch_count = 0;
    int burst_left     = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int hold_count     = 0;

    // Smallest cap on segment sums that splits vals into at most seg_cfg pieces.
    function automatic logic [OUT_W-1:0] min_max_limit(input logic [VALUE_W-1:0] vals[$],
                                                       input logic [SEG_W-1:0] seg_cfg);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned run;
        longint unsigned used;
        longint unsigned segs;
        bit              fits;
        lo = 0;
        hi = 0;
        foreach (vals[k]) begin
            hi += vals[k];
            if (vals[k] > lo) lo = vals[k];
        end
        segs = (seg_cfg == 0) ? 1 : seg_cfg;
        while (lo < hi) begin
            mid  = lo + (hi - lo) / 2;
            fits = 1'b1;
            run  = 0;
            used = 1;
            // greedy left-to-right packing, give up once too many segments
            for (int k = 0; k < vals.size() && fits; k++) begin
                if (run + vals[k] > mid) begin
                    used++;
                    run = vals[k];
                    if (used > segs) fits = 1'b0;
                end else begin
                    run += vals[k];
                end
            end
            if (fits) hi = mid;
            else lo = mid + 1;
        end
        return (lo >> OUT_W) != 0 ? '1 : lo[OUT_W-1:0];
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    endfunction

    // Offer one item, idling between bursts; record it once accepted.
    task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                elem_if.valid         <= 1'b0;
                elem_if.element_value <= $urandom;
                elem_if.last_element  <= $urandom_range(0, 1);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        elem_if.valid         <= 1'b1;
        elem_if.element_value <= value;
        elem_if.last_element  <= last;
        do @(posedge i_clk); while (!elem_if.ready);

        if (loaded_values.size() < DEPTH) loaded_values.push_back(value);
        else overflow_pending = 1'b1;
        if (last) begin
            pending_answers.push_back('{min_max_limit(loaded_values, seg_limit_shadow),
                                        overflow_pending});
            loaded_values.delete();
            overflow_pending = 1'b0;
        end
    endtask

    task automatic send_array(input int len);
        int                 style;
        logic [VALUE_W-1:0] value;
        style = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            case (style)
                0: value = $urandom;
                1: value = $urandom_range(0, 15);
                2: begin
                    case ($urandom_range(0, 4))
                        0: value = '0;
                        1: value = '1;
                        2: value = 32'd1 << $urandom_range(0, 31);
                        3: value = $urandom;
                        default: value = $urandom_range(0, 1000);
                    endcase
                end
                default: value = $urandom | 32'h8000_0000;
            endcase
            send_element(value, k == len - 1);
        end
    endtask

    // Drop valid, let every answer drain, then give the block time to clear.
    task automatic wait_idle();
        elem_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_segment_limit(input logic [APB_DW-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SEGMENT_LIMIT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seg_limit_shadow = value[SEG_W-1:0];
    endtask

    // Runs on the reset value of the limit.
    task automatic test_value_extremes();
        send_element(32'hFFFF_FFFF, 1'b1);
        send_element(32'd0, 1'b1);
        send_element(32'd0, 1'b0);
        send_element(32'd0, 1'b0);
        send_element(32'd0, 1'b1);
        send_element(32'hAAAA_AAAA, 1'b0);
        send_element(32'h5555_5555, 1'b1);
        send_element(32'd1, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'd1, 1'b1);
    endtask

    task automatic test_limit_settings();
        // zero limit acts as one segment
        set_segment_limit(32'd0);
        send_element(32'd5, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd9, 1'b1);
        set_segment_limit(32'd1024);
        send_element(32'd3, 1'b0);
        send_element(32'd9, 1'b0);
        send_element(32'd4, 1'b0);
        send_element(32'd1, 1'b1);
        // bits above the register width are ignored
        set_segment_limit(32'hFFFF_FFFF);
        send_element(32'd8, 1'b0);
        send_element(32'd2, 1'b0);
        send_element(32'd6, 1'b1);
        set_segment_limit(32'h8000_0802);
        send_element(32'd7, 1'b0);
        send_element(32'd2, 1'b0);
        send_element(32'd5, 1'b0);
        send_element(32'd10, 1'b0);
        send_element(32'd8, 1'b1);
    endtask

    // Hold the result side off while arrays keep coming, so the input stalls.
    task automatic test_result_backpressure();
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 4; n++) send_array($urandom_range(2, 6));
    endtask

    // Fill the store with the largest value, then drop two more items; the
    // closing item lands beyond the store and is dropped.
    task automatic test_store_depth();
        set_segment_limit(32'd1);
        for (int k = 0; k < DEPTH + 2; k++) send_element('1, k == DEPTH + 1);
    endtask

    task automatic test_random_arrays();
        int                sent;
        int                len;
        int                pick;
        logic [APB_DW-1:0] limit_value;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: limit_value = 32'd1;
                1: limit_value = 32'd2;
                2: limit_value = $urandom_range(3, 16);
                3: limit_value = 32'd1024;
                4: limit_value = $urandom;
                default: limit_value = $urandom_range(0, 64);
            endcase
            set_segment_limit(limit_value);
            sent = 0;
            while (sent < 70) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) len = $urandom_range(1, 8);
                else if (pick < 9) len = $urandom_range(9, 40);
                else len = $urandom_range(41, 160);
                send_array(len);
                sent += len;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end else if (hold_requests != holds_done) begin
            holds_done <= hold_requests;
            hold_count <= HOLD_CYCLES;
        end
    end

    // Result side: stall pattern that changes mode at random intervals.
    initial begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(4, 48);
            end else begin
                rx_left--;
            end
            if (hold_count != 0 || hold_requests != holds_done) begin
                res_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= $urandom_range(0, 1);
                    2: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_partition_answer want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no array pending", '0, res_if.min_max_sum);
            end else begin
                want = pending_answers.pop_front();
                if (res_if.min_max_sum !== want.min_max_sum)
                    report_mismatch("min_max_sum", want.min_max_sum, res_if.min_max_sum);
                if (res_if.overflow_flag !== want.overflow_flag)
                    report_mismatch("overflow_flag", want.overflow_flag, res_if.overflow_flag);
            end
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n               <= 1'b0;
        elem_if.valid         <= 1'b0;
        elem_if.element_value <= '0;
        elem_if.last_element  <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_value_extremes();
        test_limit_settings();
        test_result_backpressure();
        test_store_depth();
        test_random_arrays();

        wait_idle();
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
